// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_NEVER(label, clk, rst, cond, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

  // attribute used by the clearing pass after reset
  localparam logic [ATTR_W-1:0] CLEAR_ATTR_RESET = 8'd15;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // attribute source for blank fills
  typedef enum logic [1:0] {
    FILL_RESET = 2'd0,
    FILL_CLEAR = 2'd1,
    FILL_ITEM  = 2'd2
  } fill_sel_t;

  typedef struct packed {
    logic      capture;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      put;
    logic      set_cursor;
    logic      rd_cell;
    logic      copy_rd;
    logic      fill_wr;
    fill_sel_t fill_sel;
    logic      load_result;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    scroll;
    logic    copy_end;
    logic    fill_end;
    logic    out_free;
    logic    copy_pending;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// screen memory, cursor, sweep counter, item and result registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcw_datapath #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::status_t                 status,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]       cfg_data,
  input  logic [1:0]                       action,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]       attribute,
  input  logic [$clog2(SCREEN_WIDTH)-1:0]  target_column,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0] target_row,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [tcw_pkg::CELL_W-1:0]       cell_data,
  output logic [$clog2(SCREEN_WIDTH)-1:0]  cursor_column,
  output logic [$clog2(SCREEN_HEIGHT)-1:0] cursor_row
);

  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ADDR_W-1:0] WIDTH_A     = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_A      = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST_A = ADDR_W'(CELLS - SCREEN_WIDTH - 1);
  localparam logic [COL_W-1:0]  COL_MAX     = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_MAX     = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W:0]    WIDTH_C     = (COL_W + 1)'(SCREEN_WIDTH);
  localparam logic [ROW_W:0]    HEIGHT_R    = (ROW_W + 1)'(SCREEN_HEIGHT);

  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

  logic [tcw_pkg::ATTR_W-1:0] clear_attr;
  tcw_pkg::action_t           item_act;
  logic [tcw_pkg::CHAR_W-1:0] item_ch;
  logic [tcw_pkg::ATTR_W-1:0] item_attr;
  logic [COL_W-1:0]           item_col;
  logic [ROW_W-1:0]           item_row;
  logic [COL_W-1:0]           cursor_col;
  logic [ROW_W-1:0]           cursor_rw;
  logic [ADDR_W-1:0]          cnt;
  logic                       copy_wr;
  logic [ADDR_W-1:0]          copy_dst;
  logic [tcw_pkg::CELL_W-1:0] rd_data;

  logic [ADDR_W-1:0]          cur_addr;
  logic [ADDR_W-1:0]          tgt_addr;
  logic [COL_W:0]             col_inc;
  logic [ROW_W:0]             row_inc;
  logic                       put_wr;
  logic [ADDR_W-1:0]          put_addr;
  logic [tcw_pkg::CELL_W-1:0] put_data;
  logic [COL_W-1:0]           put_col;
  logic [ROW_W:0]             put_row_ext;
  logic                       scroll;
  logic [ROW_W-1:0]           put_row;
  logic [COL_W-1:0]           col_next;
  logic [ROW_W-1:0]           row_next;
  logic [tcw_pkg::ATTR_W-1:0] fill_attr;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;

  assign cur_addr = ADDR_W'(cursor_rw) * WIDTH_A + ADDR_W'(cursor_col);
  assign tgt_addr = ADDR_W'(item_row) * WIDTH_A + ADDR_W'(item_col);
  assign col_inc  = {1'b0, cursor_col} + (COL_W + 1)'(1);
  assign row_inc  = {1'b0, cursor_rw} + (ROW_W + 1)'(1);

  // put action: backspace, newline or any other character
  always_comb begin
    put_wr      = 1'b0;
    put_addr    = cur_addr;
    put_data    = {item_attr, item_ch};
    put_col     = cursor_col;
    put_row_ext = {1'b0, cursor_rw};
    if (item_ch == tcw_pkg::CHAR_BACKSPACE) begin
      if (cursor_col != '0) begin
        put_wr   = 1'b1;
        put_addr = cur_addr - ADDR_W'(1);
        put_data = {item_attr, tcw_pkg::CHAR_SPACE};
        put_col  = cursor_col - COL_W'(1);
      end
    end else if (item_ch == tcw_pkg::CHAR_NEWLINE) begin
      put_col     = '0;
      put_row_ext = row_inc;
    end else begin
      put_wr = 1'b1;
      if (col_inc >= WIDTH_C) begin
        put_col     = '0;
        put_row_ext = row_inc;
      end else begin
        put_col = col_inc[COL_W-1:0];
      end
    end
  end

  assign scroll  = (put_row_ext >= HEIGHT_R);
  assign put_row = scroll ? ROW_MAX : put_row_ext[ROW_W-1:0];

  always_comb begin
    col_next = cursor_col;
    row_next = cursor_rw;
    if (cmd.put) begin
      col_next = put_col;
      row_next = put_row;
    end else if (cmd.set_cursor) begin
      col_next = item_col;
      row_next = item_row;
    end
  end

  always_comb begin
    unique case (cmd.fill_sel)
      tcw_pkg::FILL_RESET: fill_attr = tcw_pkg::CLEAR_ATTR_RESET;
      tcw_pkg::FILL_CLEAR: fill_attr = clear_attr;
      tcw_pkg::FILL_ITEM:  fill_attr = item_attr;
      default:             fill_attr = tcw_pkg::CLEAR_ATTR_RESET;
    endcase
  end

  // single write port: pending copy, sweep fill or put
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = {fill_attr, tcw_pkg::CHAR_SPACE};
    priority if (copy_wr) begin
      wr_en   = 1'b1;
      wr_addr = copy_dst;
      wr_data = rd_data;
    end else if (cmd.fill_wr) begin
      wr_en = 1'b1;
    end else if (cmd.put && put_wr) begin
      wr_en   = 1'b1;
      wr_addr = put_addr;
      wr_data = put_data;
    end else begin
      wr_en = 1'b0;
    end
  end

  assign rd_en   = cmd.rd_cell | cmd.copy_rd;
  assign rd_addr = cmd.copy_rd ? cnt + WIDTH_A : tgt_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // item registers, target position clamped on capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_act  <= tcw_pkg::action_t'(action);
      item_ch   <= char_code;
      item_attr <= attribute;
      item_col  <= ({1'b0, target_column} >= WIDTH_C) ? COL_MAX : target_column;
      item_row  <= ({1'b0, target_row} >= HEIGHT_R) ? ROW_MAX : target_row;
    end
    copy_dst <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_attr <= tcw_pkg::CLEAR_ATTR_RESET;
      cursor_col <= '0;
      cursor_rw  <= '0;
      cnt        <= '0;
      copy_wr    <= 1'b0;
    end else begin
      if (cfg_we) begin
        clear_attr <= cfg_data;
      end
      cursor_col <= col_next;
      cursor_rw  <= row_next;
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + ADDR_W'(1);
      end
      copy_wr <= cmd.copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      cell_data     <= (item_act == tcw_pkg::ACT_READ) ? rd_data : '0;
      cursor_column <= col_next;
      cursor_row    <= row_next;
    end
  end

  always_comb begin
    status              = '0;
    status.act          = item_act;
    status.scroll       = scroll;
    status.copy_end     = (cnt == COPY_LAST_A);
    status.fill_end     = (cnt == LAST_A);
    status.out_free     = !result_valid || !result_stall;
    status.copy_pending = copy_wr;
  end

  `ASSERT_NEVER(a_col_range, clk, rst, ({1'b0, cursor_col} >= WIDTH_C), "cursor column off screen")
  `ASSERT_NEVER(a_row_range, clk, rst, ({1'b0, cursor_rw} >= HEIGHT_R), "cursor row off screen")
  `ASSERT_NEVER(a_one_writer, clk, rst, ($countones({copy_wr, cmd.fill_wr, cmd.put}) > 1), "write port conflict")

endmodule

`default_nettype wire

// ===== hdl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer for item decode, memory sweeps and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  output tcw_pkg::cmd_t    cmd,
  input  tcw_pkg::status_t status
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_CLEAR,
    S_COPY,
    S_DRAIN,
    S_BLANK,
    S_FINISH
  } state_t;

  state_t state;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = tcw_pkg::FILL_RESET;
        cmd.cnt_inc  = 1'b1;
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          cmd.cnt_clr = 1'b1;
        end
      end
      S_EXEC: begin
        unique case (status.act)
          tcw_pkg::ACT_PUT: begin
            cmd.put         = 1'b1;
            cmd.load_result = !status.scroll && status.out_free;
          end
          tcw_pkg::ACT_SET: begin
            cmd.set_cursor  = 1'b1;
            cmd.load_result = status.out_free;
          end
          tcw_pkg::ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          tcw_pkg::ACT_READ: begin
            cmd.rd_cell = 1'b1;
          end
        endcase
      end
      S_READ_WAIT, S_FINISH: begin
        cmd.load_result = status.out_free;
      end
      S_CLEAR: begin
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = tcw_pkg::FILL_CLEAR;
        cmd.cnt_inc  = 1'b1;
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_DRAIN: begin
        cmd.cnt_inc = 1'b0;
      end
      S_BLANK: begin
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = tcw_pkg::FILL_ITEM;
        cmd.cnt_inc  = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      unique case (state)
        S_INIT: begin
          if (status.fill_end) state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (status.act)
            tcw_pkg::ACT_PUT: begin
              if (status.scroll) state <= S_COPY;
              else if (status.out_free) state <= S_IDLE;
              else state <= S_FINISH;
            end
            tcw_pkg::ACT_SET: begin
              state <= status.out_free ? S_IDLE : S_FINISH;
            end
            tcw_pkg::ACT_CLEAR: begin
              state <= S_CLEAR;
            end
            tcw_pkg::ACT_READ: begin
              state <= S_READ_WAIT;
            end
          endcase
        end
        S_READ_WAIT, S_FINISH: begin
          if (status.out_free) state <= S_IDLE;
          else state <= S_FINISH;
        end
        S_CLEAR: begin
          if (status.fill_end) state <= S_FINISH;
        end
        S_COPY: begin
          if (status.copy_end) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_BLANK;
        end
        S_BLANK: begin
          if (status.fill_end) state <= S_FINISH;
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_load_free, clk, rst, cmd.load_result, status.out_free, "result register overwritten")
  `ASSERT_IMPLY(a_idle_no_copy, clk, rst, state == S_IDLE, !status.copy_pending, "copy write left pending")
  `ASSERT_NEXT(a_scroll_starts, clk, rst, cmd.put && status.scroll, cmd.copy_rd, "scroll sweep not started")

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console with a cell store, cursor, scrolling and cell readback
// ----------------------------------------------------------------------------
// The console keeps SCREEN_WIDTH x SCREEN_HEIGHT cells of 16 bits (character
// in the low byte, attribute in the high byte) in a memory with one write
// port and one registered read port, and returns one result item per accepted
// item. After reset the block runs a clearing pass over all cells that writes
// spaces in attribute 15; item_stall is high during it, while configuration
// writes are taken at any time. From accept to the result register: put and
// set cursor load the result in the execute state when the output register
// is free, read cell waits for the memory read, clear screen sweeps all cells
// first, and a put that runs off the bottom moves the rows up in a sweep over
// the memory's one read and one write per cycle, followed by blanking of the
// bottom row. The next item is taken while a finished result still waits in
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                             clk,
  input  logic                             rst,

  // configuration: clear attribute
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]       cfg_data,

  // item channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       action,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]       attribute,
  input  logic [$clog2(SCREEN_WIDTH)-1:0]  target_column,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0] target_row,

  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [tcw_pkg::CELL_W-1:0]       cell_data,
  output logic [$clog2(SCREEN_WIDTH)-1:0]  cursor_column,
  output logic [$clog2(SCREEN_HEIGHT)-1:0] cursor_row
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  // the attribute register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: decode, sweeps over the store, result hand-off
  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .status     (status)
  );

  // store, cursor, sweep counter and output register
  tcw_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_data      (cfg_data),
    .action        (action),
    .char_code     (char_code),
    .attribute     (attribute),
    .target_column (target_column),
    .target_row    (target_row),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cell_data     (cell_data),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row)
  );

endmodule

`default_nettype wire

// ===== sim/text_console_writer_checker.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_checker
// watches the item, result and configuration channels of the console writer,
// keeps its own screen, cursor and clear attribute, and compares every
// result item with the oldest prediction in line
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]       cfg_data,
  input  logic                             item_valid,
  input  logic                             item_stall,
  input  logic [1:0]                       action,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]       attribute,
  input  logic [$clog2(SCREEN_WIDTH)-1:0]  target_column,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0] target_row,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic [tcw_pkg::CELL_W-1:0]       cell_data,
  input  logic [$clog2(SCREEN_WIDTH)-1:0]  cursor_column,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0] cursor_row,
  output int                               mismatches,
  output int                               pending,
  output int                               scrolls
);

  localparam int COL_W = $clog2(SCREEN_WIDTH);
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    logic [tcw_pkg::CELL_W-1:0] cell_word;
    logic [COL_W-1:0]           col;
    logic [ROW_W-1:0]           row;
  } console_view_t;

  logic [tcw_pkg::CELL_W-1:0] screen_mem [CELLS];
  logic [tcw_pkg::ATTR_W-1:0] clear_attr;
  int                         cur_col;
  int                         cur_row;
  console_view_t              views_in_line [$];

  function automatic void fill_screen(logic [tcw_pkg::ATTR_W-1:0] attr);
    int i;
    for (i = 0; i < CELLS; i++) screen_mem[i] = {attr, tcw_pkg::CHAR_SPACE};
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // cursor and screen after one item, plus the cell read back
  function automatic console_view_t console_step(tcw_pkg::action_t act,
      logic [tcw_pkg::CHAR_W-1:0] ch, logic [tcw_pkg::ATTR_W-1:0] attr,
      logic [COL_W-1:0] tcol, logic [ROW_W-1:0] trow);
    console_view_t view;
    int col;
    int row;
    int i;
    col = (tcol >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : int'(tcol);
    row = (trow >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : int'(trow);
    view.cell_word = '0;
    case (act)
      tcw_pkg::ACT_PUT: begin
        if (ch == tcw_pkg::CHAR_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_mem[cur_row * SCREEN_WIDTH + cur_col] = {attr, tcw_pkg::CHAR_SPACE};
          end
        end else begin
          if (ch == tcw_pkg::CHAR_NEWLINE) begin
            cur_col = 0;
            cur_row++;
          end else begin
            screen_mem[cur_row * SCREEN_WIDTH + cur_col] = {attr, ch};
            cur_col++;
            if (cur_col >= SCREEN_WIDTH) begin
              cur_col = 0;
              cur_row++;
            end
          end
          // off the bottom: move rows up, blank the last in the put attribute
          if (cur_row >= SCREEN_HEIGHT) begin
            for (i = 0; i < CELLS - SCREEN_WIDTH; i++) screen_mem[i] = screen_mem[i + SCREEN_WIDTH];
            for (i = CELLS - SCREEN_WIDTH; i < CELLS; i++)
              screen_mem[i] = {attr, tcw_pkg::CHAR_SPACE};
            cur_row = SCREEN_HEIGHT - 1;
            scrolls++;
          end
        end
      end
      tcw_pkg::ACT_SET: begin
        cur_col = col;
        cur_row = row;
      end
      tcw_pkg::ACT_CLEAR: fill_screen(clear_attr);
      default: view.cell_word = screen_mem[row * SCREEN_WIDTH + col];
    endcase
    view.col = COL_W'(cur_col);
    view.row = ROW_W'(cur_row);
    return view;
  endfunction

  always @(posedge clk) begin
    console_view_t want;
    if (rst) begin
      fill_screen(tcw_pkg::CLEAR_ATTR_RESET);
      clear_attr = tcw_pkg::CLEAR_ATTR_RESET;
      cur_col = 0;
      cur_row = 0;
      views_in_line.delete();
    end else begin
      if (cfg_valid && cfg_ready) clear_attr = cfg_data;
      // results first, so a stray result is never matched to an item of this edge
      if (result_valid && !result_stall) begin
        if (views_in_line.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none got cell %h column %0d row %0d",
                   $time, cell_data, cursor_column, cursor_row);
        end else begin
          want = views_in_line.pop_front();
          check_field("cell_data", want.cell_word, cell_data);
          check_field("cursor_column", 16'(want.col), 16'(cursor_column));
          check_field("cursor_row", 16'(want.row), 16'(cursor_row));
        end
      end
      if (item_valid && !item_stall)
        views_in_line.push_back(console_step(tcw_pkg::action_t'(action), char_code,
                                             attribute, target_column, target_row));
    end
    pending <= views_in_line.size();
  end

endmodule

// ===== sim/text_console_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_tb
// drives items, stalls and clear-attribute writes into the text console
// writer; a checker beside the block predicts every result item and counts
// mismatches, and this module gives the verdict
// ----------------------------------------------------------------------------
module text_console_writer_tb;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int CHAR_W        = tcw_pkg::CHAR_W;
  localparam int ATTR_W        = tcw_pkg::ATTR_W;
  localparam int CELL_W        = tcw_pkg::CELL_W;

  // random part: three stall mixes, each split by clear-attribute writes
  localparam int SEGMENTS_PER_MIX  = 4;
  localparam int ITEMS_PER_SEGMENT = 119;

  // a clear or a scroll sweeps all cells; the clearing pass after reset too
  localparam int QUIET_LIMIT = 40000;
  localparam int TAIL_CYCLES = 16;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [ATTR_W-1:0]     cfg_data;
  logic                  item_valid;
  logic                  item_stall;
  logic [1:0]            action;
  logic [CHAR_W-1:0]     char_code;
  logic [ATTR_W-1:0]     attribute;
  logic [COL_W-1:0]      target_column;
  logic [ROW_W-1:0]      target_row;
  logic                  result_valid;
  logic                  result_stall;
  logic [CELL_W-1:0]     cell_data;
  logic [COL_W-1:0]      cursor_column;
  logic [ROW_W-1:0]      cursor_row;

  int mismatches;
  int pending;
  int scrolls;

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int items_by_action [4];
  int attr_writes;
  int quiet_cycles;
  logic [ROW_W-1:0] last_set_row;

  text_console_writer #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_top (.*);

  text_console_writer_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver stalls at random, independent of anything else
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending);
      $display("status: fail");
      $finish;
    end
  end

  // one item: optional random gap, then hold valid and payload until taken;
  // valid stays high on return so back-to-back items never drop it
  task automatic send_item(tcw_pkg::action_t act, logic [CHAR_W-1:0] ch,
                           logic [ATTR_W-1:0] attr,
                           logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    action        <= act;
    char_code     <= ch;
    attribute     <= attr;
    target_column <= col;
    target_row    <= row;
    do @(posedge clk); while (item_stall);
    items_sent++;
    items_by_action[act]++;
    if (act == tcw_pkg::ACT_SET) last_set_row = row;
  endtask

  // idle the item channel and wait until every result item is back;
  // one edge first so the checker's count covers the last accepted item
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_clear_attr(logic [ATTR_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr_writes++;
  endtask

  // one burst of traffic: mostly runs of text, with cursor moves, reads
  // and the odd clear mixed in
  task automatic random_burst();
    int pick;
    int roll;
    logic [ATTR_W-1:0] run_attr;
    logic [CHAR_W-1:0] ch;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // a run of text in mostly one attribute, with newlines and backspaces
      run_attr = ATTR_W'($urandom);
      repeat ($urandom_range(16, 1)) begin
        roll = $urandom_range(99);
        if (roll < 8)
          ch = tcw_pkg::CHAR_NEWLINE;
        else if (roll < 15)
          ch = tcw_pkg::CHAR_BACKSPACE;
        else
          ch = CHAR_W'($urandom);
        if ($urandom_range(9) == 0) run_attr = ATTR_W'($urandom);
        send_item(tcw_pkg::ACT_PUT, ch, run_attr, COL_W'($urandom), ROW_W'($urandom));
      end
    end else if (pick < 75) begin
      roll = $urandom_range(99);
      if (roll < 70)
        send_item(tcw_pkg::ACT_SET, CHAR_W'($urandom), ATTR_W'($urandom),
                  COL_W'($urandom_range(SCREEN_WIDTH - 1)),
                  ROW_W'($urandom_range(SCREEN_HEIGHT - 1)));
      else if (roll < 80)
        // end of the bottom row, so the next text scrolls soon
        send_item(tcw_pkg::ACT_SET, CHAR_W'($urandom), ATTR_W'($urandom),
                  COL_W'($urandom_range(SCREEN_WIDTH - 1, SCREEN_WIDTH - 10)),
                  ROW_W'(SCREEN_HEIGHT - 1));
      else
        // anywhere the field allows, out of range included
        send_item(tcw_pkg::ACT_SET, CHAR_W'($urandom), ATTR_W'($urandom),
                  COL_W'($urandom), ROW_W'($urandom));
    end else if (pick < 96) begin
      // half the reads land on the row last moved to, where text tends to be
      if ($urandom_range(1) == 0)
        send_item(tcw_pkg::ACT_READ, CHAR_W'($urandom), ATTR_W'($urandom),
                  COL_W'($urandom_range(SCREEN_WIDTH - 1)), last_set_row);
      else
        send_item(tcw_pkg::ACT_READ, CHAR_W'($urandom), ATTR_W'($urandom),
                  COL_W'($urandom), ROW_W'($urandom));
    end else begin
      send_item(tcw_pkg::ACT_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom),
                COL_W'($urandom), ROW_W'($urandom));
    end
  endtask

  initial begin
    int segment_end;
    logic [ATTR_W-1:0] attr_value;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    item_valid    <= 1'b0;
    action        <= tcw_pkg::ACT_PUT;
    char_code     <= '0;
    attribute     <= '0;
    target_column <= '0;
    target_row    <= '0;
    result_stall  <= 1'b0;
    last_set_row   = '0;
    send_idle_pct  = 17;
    recv_idle_pct  = 72;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // the clearing pass after reset holds off items; the register is free
    write_clear_attr(8'h4E);

    // directed: fresh screen, clamped read, put extremes, backspace cases
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_READ, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_item(tcw_pkg::ACT_PUT, 8'h41, 8'h00, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_PUT, 8'hFF, 8'hFF, 7'd127, 5'd31);
    // backspace blanks in its own attribute, nothing lingers afterwards
    send_item(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_BACKSPACE, 8'h3C, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0);
    send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 7'd0, 5'd0);
    // backspace at column zero leaves everything alone
    send_item(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_BACKSPACE, 8'hC3, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_PUT, 8'h00, 8'h55, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_NEWLINE, 8'h12, 7'd0, 5'd0);
    // cursor set past both edges clamps to the last cell
    send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 7'd127, 5'd31);
    // wrap off the last cell scrolls, new bottom row in the put attribute
    send_item(tcw_pkg::ACT_PUT, 8'h5A, 8'h7E, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd79, 5'd23);
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd5, 5'd24);
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    // newline on the bottom row scrolls too
    send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 7'd0, 5'd24);
    send_item(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_NEWLINE, 8'hA5, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 7'd80, 5'd3);
    send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 7'd3, 5'd25);
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd127, 5'd0);
    // clear uses the register, the cursor stays put
    send_item(tcw_pkg::ACT_CLEAR, 8'hFF, 8'hFF, 7'd0, 5'd0);
    send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 7'd40, 5'd12);

    // random: sender light / receiver heavy, the reverse, then no stalls
    for (int mix = 0; mix < 3; mix++) begin
      send_idle_pct = (mix == 0) ? 17 : (mix == 1) ? 72 : 0;
      recv_idle_pct = (mix == 0) ? 72 : (mix == 1) ? 17 : 0;
      for (int seg = 0; seg < SEGMENTS_PER_MIX; seg++) begin
        // register extremes first in each mix, then random values
        attr_value = (seg == 0) ? 8'hFF : (seg == 1) ? 8'h00 : ATTR_W'($urandom);
        write_clear_attr(attr_value);
        // every segment opens with a clear so the new attribute is seen
        send_item(tcw_pkg::ACT_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom),
                  COL_W'($urandom), ROW_W'($urandom));
        segment_end = items_sent + ITEMS_PER_SEGMENT;
        while (items_sent < segment_end) random_burst();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d items: %0d puts, %0d cursor sets, %0d clears, %0d reads",
             items_sent, items_by_action[tcw_pkg::ACT_PUT],
             items_by_action[tcw_pkg::ACT_SET], items_by_action[tcw_pkg::ACT_CLEAR],
             items_by_action[tcw_pkg::ACT_READ]);
    $display("%0d scrolls, %0d clear-attribute writes, three stall mixes, %0d mismatches",
             scrolls, attr_writes, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
sim/text_console_writer_checker.sv
sim/text_console_writer_tb.sv
